FILE: rtl/e2rm_pkg.sv
// Package for the Euler angle to rotation matrix block.
// Holds payload structs, fixed-point constants and the CORDIC arctangent table.
// No dependencies.
`default_nettype none
package e2rm_pkg;

  localparam int unsigned AngW    = 16;
  localparam int unsigned EntW    = 16;
  localparam int unsigned XyW     = 34;
  localparam int unsigned XyFrac  = 30;
  localparam logic signed [XyW-1:0] CordicGain = 34'sh026DD3B6A;
  localparam logic signed [EntW-1:0] OneQ14 = 16'sd16384;
  localparam logic signed [EntW-1:0] MinusOneQ14 = -16'sd16384;

  typedef struct packed {
    logic signed [AngW-1:0] roll_angle;
    logic signed [AngW-1:0] pitch_angle;
    logic signed [AngW-1:0] yaw_angle;
  } e2rm_in_t;

  typedef struct packed {
    logic signed [EntW-1:0] m00;
    logic signed [EntW-1:0] m01;
    logic signed [EntW-1:0] m02;
    logic signed [EntW-1:0] m10;
    logic signed [EntW-1:0] m11;
    logic signed [EntW-1:0] m12;
    logic signed [EntW-1:0] m20;
    logic signed [EntW-1:0] m21;
    logic signed [EntW-1:0] m22;
  } e2rm_out_t;

  // unsigned long division, used for elaboration-time constants only
  function automatic logic [63:0] const_div(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) in Q60
  function automatic logic signed [63:0] atan_q60(input int i);
    logic signed [63:0] sum;
    int e;
    sum = 64'sh0;
    if (i == 0) begin
      sum = 64'sh0C90FDAA22168C23;
    end else begin
      for (int k = 0; k < 64; k++) begin
        e = 60 - i * (2 * k + 1);
        if (e >= 0) begin
          if ((k & 1) != 0) begin
            sum = sum - $signed(const_div(64'h1 << e, 64'(2 * k + 1)));
          end else begin
            sum = sum + $signed(const_div(64'h1 << e, 64'(2 * k + 1)));
          end
        end
      end
    end
    return sum;
  endfunction

  // round a Q60 value half up to fb fraction bits
  function automatic logic signed [63:0] round_q60(input logic signed [63:0] v, input int fb);
    return (v + (64'sh1 <<< (59 - fb))) >>> (60 - fb);
  endfunction

  function automatic logic signed [EntW-1:0] clamp_q14(input logic signed [63:0] v);
    logic signed [EntW-1:0] r;
    if (v > 64'sd16384) begin
      r = OneQ14;
    end else if (v < -64'sd16384) begin
      r = MinusOneQ14;
    end else begin
      r = v[EntW-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/euler_to_rotation_matrix.sv
// Euler ZYX angles to rotation matrix: top level with CORDIC cell chain and matrix stages.
// Depends on e2rm_pkg, e2rm_cordic_cell, e2rm_matrix.
//
// Usage: in channel carries roll/pitch/yaw (Q2.13 rad) as one transfer of
// e2rm_in_t; out channel returns nine Q1.14 entries as e2rm_out_t.
// The pipeline holds one fold stage, CORDIC_STEPS CORDIC cells and four
// product/rounding stages between an input transfer and its output transfer.
// Throughput is one transfer per cycle while the output is not stalled.
// The whole pipeline advances when the output register is empty or taken,
// so in_stall_o equals out_stall_i while the output holds a result.
// Reset clears only the valid bits of all stages; payload is not reset.
// A stalled output keeps its payload and valid until taken.
`default_nettype none
module euler_to_rotation_matrix #(
  parameter int unsigned CORDIC_STEPS = 16,
  parameter int unsigned ANGLE_BITS = 16
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  wire e2rm_pkg::e2rm_in_t in_data_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output e2rm_pkg::e2rm_out_t  out_data_o
);
  import e2rm_pkg::*;

  localparam int unsigned ZW = ANGLE_BITS + 4;
  localparam int unsigned Depth = CORDIC_STEPS + 5;
  localparam logic signed [ZW-1:0] HalfPi = ZW'(round_q60(64'sh0C90FDAA22168C23 * 2, ANGLE_BITS));
  localparam logic signed [ZW-1:0] FullPi = ZW'(round_q60(64'sh0C90FDAA22168C23 * 4, ANGLE_BITS));

  logic en;
  logic [Depth-1:0] vld_q;
  assign en = !(vld_q[Depth-1] && out_stall_i);
  assign in_stall_o = !en;
  assign out_valid_o = vld_q[Depth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], in_valid_i};
    end
  end

  // fold stage
  logic signed [AngW-1:0] ang [3];
  logic signed [ZW-1:0] z_conv [3];
  logic [2:0][XyW-1:0] x_c [CORDIC_STEPS+1];
  logic [2:0][XyW-1:0] y_c [CORDIC_STEPS+1];
  logic [2:0][ZW-1:0]  z_c [CORDIC_STEPS+1];
  logic [2:0]          f_c [CORDIC_STEPS+1];
  logic [2:0][ZW-1:0]  z0_q;
  logic [2:0]          f0_q;

  assign ang[0] = in_data_i.roll_angle;
  assign ang[1] = in_data_i.pitch_angle;
  assign ang[2] = in_data_i.yaw_angle;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (ANGLE_BITS >= 13) begin
        z_conv[a] = ZW'(ang[a]) <<< (ANGLE_BITS - 13);
      end else begin
        z_conv[a] = ZW'(ang[a] >>> (13 - ANGLE_BITS));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        if (z_conv[a] > HalfPi) begin
          z0_q[a] <= z_conv[a] - FullPi;
          f0_q[a] <= 1'b1;
        end else if (z_conv[a] < -HalfPi) begin
          z0_q[a] <= z_conv[a] + FullPi;
          f0_q[a] <= 1'b1;
        end else begin
          z0_q[a] <= z_conv[a];
          f0_q[a] <= 1'b0;
        end
      end
    end
  end

  assign x_c[0] = {3{CordicGain}};
  assign y_c[0] = '0;
  assign z_c[0] = z0_q;
  assign f_c[0] = f0_q;

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
    e2rm_cordic_cell #(
      .STEP(g),
      .ZW(ZW),
      .ATAN(ZW'(round_q60(atan_q60(g), ANGLE_BITS)))
    ) u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .x_i   (x_c[g]),
      .y_i   (y_c[g]),
      .z_i   (z_c[g]),
      .flip_i(f_c[g]),
      .x_o   (x_c[g+1]),
      .y_o   (y_c[g+1]),
      .z_o   (z_c[g+1]),
      .flip_o(f_c[g+1])
    );
  end

  e2rm_matrix u_matrix (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (x_c[CORDIC_STEPS]),
    .y_i   (y_c[CORDIC_STEPS]),
    .flip_i(f_c[CORDIC_STEPS]),
    .mat_o (out_data_o)
  );

  logic unused_z;
  assign unused_z = ^z_c[CORDIC_STEPS];
endmodule
`default_nettype wire

FILE: rtl/e2rm_cordic_cell.sv
// One CORDIC rotation cell: handles one iteration for all three angles.
// Depends on e2rm_pkg.
`default_nettype none
module e2rm_cordic_cell #(
  parameter int unsigned STEP = 0,
  parameter int unsigned ZW = 20,
  parameter logic signed [ZW-1:0] ATAN = '0
) (
  input  wire                                clk_i,
  input  wire                                en_i,
  input  wire logic signed [2:0][e2rm_pkg::XyW-1:0] x_i,
  input  wire logic signed [2:0][e2rm_pkg::XyW-1:0] y_i,
  input  wire logic signed [2:0][ZW-1:0]     z_i,
  input  wire logic [2:0]                    flip_i,
  output logic signed [2:0][e2rm_pkg::XyW-1:0] x_o,
  output logic signed [2:0][e2rm_pkg::XyW-1:0] y_o,
  output logic signed [2:0][ZW-1:0]          z_o,
  output logic [2:0]                         flip_o
);
  import e2rm_pkg::*;

  logic signed [2:0][XyW-1:0] x_d, y_d;
  logic signed [2:0][ZW-1:0]  z_d;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (!z_i[a][ZW-1]) begin
        x_d[a] = $signed(x_i[a]) - ($signed(y_i[a]) >>> STEP);
        y_d[a] = $signed(y_i[a]) + ($signed(x_i[a]) >>> STEP);
        z_d[a] = z_i[a] - ATAN;
      end else begin
        x_d[a] = $signed(x_i[a]) + ($signed(y_i[a]) >>> STEP);
        y_d[a] = $signed(y_i[a]) - ($signed(x_i[a]) >>> STEP);
        z_d[a] = z_i[a] + ATAN;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_o    <= x_d;
      y_o    <= y_d;
      z_o    <= z_d;
      flip_o <= flip_i;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/e2rm_matrix.sv
// Matrix product stages: sine/cosine rounding, pair products, triple products, rounding.
// Depends on e2rm_pkg.
`default_nettype none
module e2rm_matrix (
  input  wire                                clk_i,
  input  wire                                en_i,
  input  wire logic signed [2:0][e2rm_pkg::XyW-1:0] x_i,
  input  wire logic signed [2:0][e2rm_pkg::XyW-1:0] y_i,
  input  wire logic [2:0]                    flip_i,
  output e2rm_pkg::e2rm_out_t                mat_o
);
  import e2rm_pkg::*;

  localparam logic signed [XyW-1:0] RndXy = XyW'(1) <<< (XyFrac - 15);

  // stage A: sin/cos in Q1.14
  logic signed [EntW-1:0] s_q [3];
  logic signed [EntW-1:0] c_q [3];
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int a = 0; a < 3; a++) begin
        s_q[a] <= clamp_q14(64'((flip_i[a] ? -$signed(y_i[a]) : $signed(y_i[a])) + RndXy)
                            >>> (XyFrac - 14));
        c_q[a] <= clamp_q14(64'((flip_i[a] ? -$signed(x_i[a]) : $signed(x_i[a])) + RndXy)
                            >>> (XyFrac - 14));
      end
    end
  end

  // 0 roll, 1 pitch, 2 yaw
  logic signed [31:0] srsp_q, crsp_q, cpcy_q, cpsy_q, crsy_q, srsy_q, crcy_q, srcy_q;
  logic signed [31:0] srcp_q, crcp_q;
  logic signed [EntW-1:0] cy_q, sy_q, msp_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      srsp_q <= 32'(s_q[0]) * 32'(s_q[1]);
      crsp_q <= 32'(c_q[0]) * 32'(s_q[1]);
      cpcy_q <= 32'(c_q[1]) * 32'(c_q[2]);
      cpsy_q <= 32'(c_q[1]) * 32'(s_q[2]);
      crsy_q <= 32'(c_q[0]) * 32'(s_q[2]);
      srsy_q <= 32'(s_q[0]) * 32'(s_q[2]);
      crcy_q <= 32'(c_q[0]) * 32'(c_q[2]);
      srcy_q <= 32'(s_q[0]) * 32'(c_q[2]);
      srcp_q <= 32'(s_q[0]) * 32'(c_q[1]);
      crcp_q <= 32'(c_q[0]) * 32'(c_q[1]);
      cy_q   <= c_q[2];
      sy_q   <= s_q[2];
      msp_q  <= clamp_q14(-64'(s_q[1]));
    end
  end

  // stage C: Q42 sums
  logic signed [47:0] t01_q, t02_q, t11_q, t12_q;
  logic signed [31:0] p00_q, p10_q, p21_q, p22_q;
  logic signed [EntW-1:0] msp2_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t01_q  <= 48'(srsp_q) * 48'(cy_q) - (48'(crsy_q) <<< 14);
      t02_q  <= 48'(crsp_q) * 48'(cy_q) + (48'(srsy_q) <<< 14);
      t11_q  <= 48'(srsp_q) * 48'(sy_q) + (48'(crcy_q) <<< 14);
      t12_q  <= 48'(crsp_q) * 48'(sy_q) - (48'(srcy_q) <<< 14);
      p00_q  <= cpcy_q;
      p10_q  <= cpsy_q;
      p21_q  <= srcp_q;
      p22_q  <= crcp_q;
      msp2_q <= msp_q;
    end
  end

  function automatic logic signed [EntW-1:0] q28(input logic signed [31:0] v);
    return clamp_q14(64'(v + 32'sd8192) >>> 14);
  endfunction
  function automatic logic signed [EntW-1:0] q42(input logic signed [47:0] v);
    return clamp_q14(64'(v + 48'sd134217728) >>> 28);
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mat_o.m00 <= q28(p00_q);
      mat_o.m01 <= q42(t01_q);
      mat_o.m02 <= q42(t02_q);
      mat_o.m10 <= q28(p10_q);
      mat_o.m11 <= q42(t11_q);
      mat_o.m12 <= q42(t12_q);
      mat_o.m20 <= msp2_q;
      mat_o.m21 <= q28(p21_q);
      mat_o.m22 <= q28(p22_q);
    end
  end
endmodule
`default_nettype wire

FILE: rtl/e2rm_checker.sv
// Port-level checker for euler_to_rotation_matrix, bound to the top level.
// Depends on e2rm_pkg.
`default_nettype none
module e2rm_sva (
  input wire clk_i,
  input wire rst_ni,
  input wire in_stall_o,
  input wire out_valid_o,
  input wire out_stall_i,
  input wire e2rm_pkg::e2rm_out_t out_data_o
);
  import e2rm_pkg::*;

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");
  a_in_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output stall");
  a_m20_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.m20 <= OneQ14 && out_data_o.m20 >= MinusOneQ14)
    else $error("m20 out of range");
  a_m00_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.m00 <= OneQ14 && out_data_o.m00 >= MinusOneQ14)
    else $error("m00 out of range");
endmodule

bind euler_to_rotation_matrix e2rm_sva u_e2rm_sva (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);
`default_nettype wire

FILE: bench/e2rm_checker.sv
// Checker for euler_to_rotation_matrix: watches both channels, predicts each matrix
// with its own CORDIC model and compares entry by entry. Depends on e2rm_pkg.
`timescale 1ns / 100ps
module e2rm_checker #(
  parameter int unsigned CORDIC_STEPS = 16,
  parameter int unsigned ANGLE_BITS = 16
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  input  wire                 in_stall_i,
  input  wire e2rm_pkg::e2rm_in_t  in_data_i,
  input  wire                 out_valid_i,
  input  wire                 out_stall_i,
  input  wire e2rm_pkg::e2rm_out_t out_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  import e2rm_pkg::*;

  e2rm_out_t matrix_q[$];

  assign pending_o = matrix_q.size();

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint to_frac(longint v);
    int s;
    s = 60 - ANGLE_BITS;
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint arctan_step(int i);
    longint acc;
    int e;
    acc = 0;
    if (i == 0) return to_frac(64'sh0C90FDAA22168C23);
    for (int k = 0; k < 64; k++) begin
      e = 60 - i * (2 * k + 1);
      if (e < 0) break;
      if (k & 1) acc -= (64'sd1 <<< e) / (2 * k + 1);
      else acc += (64'sd1 <<< e) / (2 * k + 1);
    end
    return to_frac(acc);
  endfunction

  function automatic longint sat14(longint v);
    if (v > 16384) return 16384;
    if (v < -16384) return -16384;
    return v;
  endfunction

  task automatic trig(input logic signed [15:0] ang, output longint sn, output longint cs);
    longint z, x, y, hp, pi, dx, dy, a;
    bit flip;
    int sh;
    sh = int'(ANGLE_BITS) - 13;
    z = ang;
    if (sh >= 0) z = z <<< sh;
    else z = z >>> (-sh);
    hp = to_frac(64'sh0C90FDAA22168C23 * 2);
    pi = to_frac(64'sh0C90FDAA22168C23 * 4);
    flip = 0;
    if (z > hp) begin
      z -= pi;
      flip = 1;
    end else if (z < -hp) begin
      z += pi;
      flip = 1;
    end
    x = 64'sh26DD3B6A;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = shr_floor(y, i);
      dy = shr_floor(x, i);
      a = arctan_step(i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= a;
      end else begin
        x += dx; y -= dy; z += a;
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    cs = sat14((x + (64'sd1 <<< 15)) >>> 16);
    sn = sat14((y + (64'sd1 <<< 15)) >>> 16);
  endtask

  function automatic logic signed [15:0] q28(longint v);
    return 16'(sat14((v + (64'sd1 <<< 13)) >>> 14));
  endfunction

  function automatic logic signed [15:0] q42(longint v);
    return 16'(sat14((v + (64'sd1 <<< 27)) >>> 28));
  endfunction

  task automatic predict_matrix(input e2rm_in_t a, output e2rm_out_t m);
    longint sr, cr, sp, cp, sy, cy;
    trig(a.roll_angle, sr, cr);
    trig(a.pitch_angle, sp, cp);
    trig(a.yaw_angle, sy, cy);
    m.m00 = q28(cp * cy);
    m.m01 = q42(sr * sp * cy - cr * sy * 16384);
    m.m02 = q42(cr * sp * cy + sr * sy * 16384);
    m.m10 = q28(cp * sy);
    m.m11 = q42(sr * sp * sy + cr * cy * 16384);
    m.m12 = q42(cr * sp * sy - sr * cy * 16384);
    m.m20 = 16'(sat14(-sp));
    m.m21 = q28(sr * cp);
    m.m22 = q28(cr * cp);
  endtask

  task automatic report(input string msg);
    $display("%0t mismatch %s", $realtime, msg);
    fail_count_o++;
  endtask

  function automatic string diff(input string what, input logic signed [15:0] got,
                                 input logic signed [15:0] want);
    return $sformatf("%s: got %0d expected %0d", what, got, want);
  endfunction

  initial fail_count_o = 0;

  always @(posedge clk_i) begin
    e2rm_out_t m, w;
    if (rst_ni && in_valid_i && !in_stall_i) begin
      predict_matrix(in_data_i, m);
      matrix_q.push_back(m);
    end
    if (rst_ni && out_valid_i && !out_stall_i) begin
      if (matrix_q.size() == 0) begin
        report("result transfer with none expected");
      end else begin
        w = matrix_q.pop_front();
        m = out_data_i;
        if (m.m00 !== w.m00) report(diff("m00", m.m00, w.m00));
        if (m.m01 !== w.m01) report(diff("m01", m.m01, w.m01));
        if (m.m02 !== w.m02) report(diff("m02", m.m02, w.m02));
        if (m.m10 !== w.m10) report(diff("m10", m.m10, w.m10));
        if (m.m11 !== w.m11) report(diff("m11", m.m11, w.m11));
        if (m.m12 !== w.m12) report(diff("m12", m.m12, w.m12));
        if (m.m20 !== w.m20) report(diff("m20", m.m20, w.m20));
        if (m.m21 !== w.m21) report(diff("m21", m.m21, w.m21));
        if (m.m22 !== w.m22) report(diff("m22", m.m22, w.m22));
      end
    end
  end
endmodule

FILE: bench/tb.sv
// Testbench top for euler_to_rotation_matrix: drives angle triples with random gaps
// and output stalls, checks through e2rm_checker. Depends on e2rm_pkg.
`timescale 1ns / 100ps
module tb;
  import e2rm_pkg::*;

  localparam int NumRandom = 500;
  localparam int CycleLimit = 200000;
  localparam int Drain = 40;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic out_stall = 0;
  logic in_stall, out_valid;
  e2rm_in_t in_data = '0;
  e2rm_out_t out_data;
  int fail_count, pending, cycles = 0;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  euler_to_rotation_matrix u_dut (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_stall_o(in_stall),
    .in_data_i(in_data), .out_valid_o(out_valid), .out_stall_i(out_stall),
    .out_data_o(out_data)
  );

  e2rm_checker u_chk (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_stall_i(in_stall),
    .in_data_i(in_data), .out_valid_i(out_valid), .out_stall_i(out_stall),
    .out_data_i(out_data), .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: per result, optionally hold stall before taking it; some stretches with none
  initial begin
    int w;
    bit calm;
    forever begin
      calm = ($urandom_range(0, 3) == 0);
      repeat (20) begin
        w = calm ? 0 : $urandom_range(0, 9);
        @(negedge clk);
        if (w > 0) begin
          out_stall <= 1;
          repeat (w) @(negedge clk);
        end
        out_stall <= 0;
        do @(posedge clk); while (!(out_valid && !out_stall));
      end
    end
  end

  function automatic logic signed [15:0] rand_angle();
    case ($urandom_range(0, 5))
      0: return 16'(int'($urandom_range(0, 51472)) - 25736);
      1: return 16'($urandom);
      2: return 16'(int'($urandom_range(0, 400)) - 200);
      3: return 16'(int'($urandom_range(12668, 13068)) * ($urandom_range(0, 1) ? 1 : -1));
      4: return 16'(int'($urandom_range(25536, 25736)) * ($urandom_range(0, 1) ? 1 : -1));
      default: return 16'(int'($urandom_range(0, 65535)) - 32768);
    endcase
  endfunction

  task automatic send(input logic signed [15:0] r, p, y, input bit calm);
    int w;
    w = calm ? 0 : $urandom_range(0, 9);
    if (w > 0) begin
      in_valid <= 0;
      repeat (w) @(negedge clk);
    end
    in_data <= '{roll_angle: r, pitch_angle: p, yaw_angle: y};
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  initial begin
    logic signed [15:0] dir[12];
    bit calm;
    dir = '{16'sd0, 16'sd25736, -16'sd25736, 16'sd12868, -16'sd12868, 16'sd12869,
            -16'sd12869, 16'sd6434, 16'sh7FFF, 16'sh8000, 16'sd1, -16'sd1};
    repeat (8) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    foreach (dir[i]) send(dir[i], dir[(i + 3) % 12], dir[(i + 7) % 12], 0);
    send(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1);
    send(16'sh8000, 16'sh8000, 16'sh8000, 1);
    send(16'sh5555, 16'shAAAA, 16'sh5555, 0);
    send(16'shAAAA, 16'sh5555, 16'shAAAA, 0);
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    calm = 0;
    for (int i = 0; i < NumRandom; i++) begin
      if (i % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      send(rand_angle(), rand_angle(), rand_angle(), calm);
    end
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (Drain) @(negedge clk);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
